// ----- sv/rotation_matrix_to_quaternion_top_defines.svh -----
// Assertion macros used by the port-level checker.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH

// Check a property outside reset.
`define RMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define RMQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/rmq_pkg.sv -----
`timescale 1ns / 1ps
package rmq_pkg;

  // Width of one matrix entry and one quaternion component.
  localparam int MW = 16;
  // Width of a paired sum or difference of two entries.
  localparam int DIFW = MW + 1;

  // Component picked as the largest one.
  typedef enum logic [1:0] {
    PICK_W = 2'd0,
    PICK_X = 2'd1,
    PICK_Y = 2'd2,
    PICK_Z = 2'd3
  } pick_t;

  localparam logic signed [MW-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [MW-1:0] SAT_MIN = 16'sh8000;

endpackage

// ----- sv/rmq_sqrt_cell.sv -----
`timescale 1ns / 1ps
// One step of the digit-by-digit square root: takes two radicand bits,
// yields one root bit, and hands everything on to the next cell.
module rmq_sqrt_cell #(
  parameter int VW = 30,
  parameter int HW = 15,
  parameter int SW = 57
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          valid_in,
  input  logic [VW-1:0] rad_in,
  input  logic [HW+1:0] rem_in,
  input  logic [HW-1:0] root_in,
  input  logic [SW-1:0] side_in,
  output logic          valid_out,
  output logic [VW-1:0] rad_out,
  output logic [HW+1:0] rem_out,
  output logic [HW-1:0] root_out,
  output logic [SW-1:0] side_out
);

  logic          valid_r;
  logic [VW-1:0] rad_r;
  logic [HW+1:0] rem_r;
  logic [HW-1:0] root_r;
  logic [SW-1:0] side_r;
  logic [HW+3:0] acc;
  logic [HW+3:0] trial;
  logic [HW+1:0] rem_nxt;
  logic [HW-1:0] root_nxt;

  // Bring down two bits and try the next root bit.
  always_comb begin
    acc   = {rem_in, rad_in[VW-1 -: 2]};
    trial = {2'b00, root_in, 2'b01};
    if (acc >= trial) begin
      rem_nxt  = (HW+2)'(acc - trial);
      root_nxt = {root_in[HW-2:0], 1'b1};
    end else begin
      rem_nxt  = acc[HW+1:0];
      root_nxt = {root_in[HW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  // Advance the payload; hold it while the chain is stalled.
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_in[VW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_in;
    end
  end

  assign valid_out = valid_r;
  assign rad_out   = rad_r;
  assign rem_out   = rem_r;
  assign root_out  = root_r;
  assign side_out  = side_r;

endmodule

// ----- sv/rmq_div_cell.sv -----
`timescale 1ns / 1ps
// One restoring-division step on three lanes that share a divisor.
// Each lane's word holds the dividend bits not yet used on top and the
// quotient bits found so far at the bottom.
module rmq_div_cell #(
  parameter int NUMW = 32,
  parameter int DW   = 17,
  parameter int SW   = 21
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    valid_in,
  input  logic [DW-1:0]           den_in,
  input  logic [2:0][NUMW-1:0]    nq_in,
  input  logic [2:0][DW-1:0]      rem_in,
  input  logic [SW-1:0]           side_in,
  output logic                    valid_out,
  output logic [DW-1:0]           den_out,
  output logic [2:0][NUMW-1:0]    nq_out,
  output logic [2:0][DW-1:0]      rem_out,
  output logic [SW-1:0]           side_out
);

  logic                 valid_r;
  logic [DW-1:0]        den_r;
  logic [2:0][NUMW-1:0] nq_r;
  logic [2:0][DW-1:0]   rem_r;
  logic [SW-1:0]        side_r;
  logic [2:0][NUMW-1:0] nq_nxt;
  logic [2:0][DW-1:0]   rem_nxt;
  logic [DW:0]          acc [3];

  // Shift in one dividend bit per lane and subtract where it fits.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = {rem_in[k], nq_in[k][NUMW-1]};
      if (acc[k] >= {1'b0, den_in}) begin
        rem_nxt[k] = DW'(acc[k] - {1'b0, den_in});
        nq_nxt[k]  = {nq_in[k][NUMW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = acc[k][DW-1:0];
        nq_nxt[k]  = {nq_in[k][NUMW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  // Advance the payload; hold it while the chain is stalled.
  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= den_in;
      nq_r   <= nq_nxt;
      rem_r  <= rem_nxt;
      side_r <= side_in;
    end
  end

  assign valid_out = valid_r;
  assign den_out   = den_r;
  assign nq_out    = nq_r;
  assign rem_out   = rem_r;
  assign side_out  = side_r;

endmodule

// ----- sv/rotation_matrix_to_quaternion_top.sv -----
`timescale 1ns / 1ps
// Rotation matrix to quaternion converter.
// Slave channel in_*: one 3x3 matrix per transfer, nine signed entries with
// FRAC_BITS fraction bits packed in in_tdata. Master channel out_*: the
// quaternion x, y, z, w in out_tdata and the invalid flag in out_tuser.
// The block picks the largest of trace and diagonal differences, takes a
// square root for that component and divides the three off-diagonal pairs
// by it. Everything runs in a chain of cells: one front stage, one
// square-root cell per root bit, one division cell per quotient bit (three
// lanes side by side), and an output register.
// The root has HW bits and each quotient NUMW = FRAC_BITS + 18 bits.
// Throughput: one matrix per cycle while out_tready is high.
// When the receiver stalls, the whole chain holds and in_tready falls in the
// same cycle; it rises again as soon as the waiting result is taken.
// Reset (rst_n low, synchronous) empties every stage; no result is pending.
module rotation_matrix_to_quaternion_top #(
  parameter int FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // row0_col0, row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
  // row2_col0, row2_col1, row2_col2 (16 bits each, from bit 0 up)
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // quat_x, quat_y, quat_z, quat_w (16 bits each, from bit 0 up)
  output logic [63:0]  out_tdata,
  // invalid
  output logic         out_tuser
);

  localparam int MW   = rmq_pkg::MW;
  localparam int DIFW = rmq_pkg::DIFW;
  localparam int BW   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
  localparam int VW0  = BW + FRAC_BITS - 2;
  localparam int HW   = (VW0 + 1) / 2;
  localparam int VW   = 2 * HW;
  localparam int DW   = HW + 2;
  localparam int NUMW = FRAC_BITS + 18;
  localparam int SW1  = 3 * DIFW + 6;
  localparam int SW2  = 6 + HW;

  logic en;
  logic signed [MW-1:0] m [9];
  logic signed [MW+1:0] c0, c1, c2, c3, big;
  rmq_pkg::pick_t pick;
  logic signed [BW:0] b1;
  logic inv;
  logic signed [DIFW-1:0] d [3];
  logic [2:0] sgn;
  logic [2:0][DIFW-1:0] mag;

  logic          valid0_r;
  logic [VW-1:0] rad0_r;
  logic [SW1-1:0] side0_r;

  // Stall the whole chain while a result waits at the output.
  assign en        = !out_tvalid | out_tready;
  assign in_tready = en;

  // Candidates, largest pick and paired sums and differences.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      m[k] = in_tdata[k*MW +: MW];
    end
    c0 = (MW+2)'(m[0]) + (MW+2)'(m[4]) + (MW+2)'(m[8]);
    c1 = (MW+2)'(m[0]) - (MW+2)'(m[4]) - (MW+2)'(m[8]);
    c2 = (MW+2)'(m[4]) - (MW+2)'(m[0]) - (MW+2)'(m[8]);
    c3 = (MW+2)'(m[8]) - (MW+2)'(m[0]) - (MW+2)'(m[4]);
    big  = c0;
    pick = rmq_pkg::PICK_W;
    if (c1 > big) begin
      big  = c1;
      pick = rmq_pkg::PICK_X;
    end
    if (c2 > big) begin
      big  = c2;
      pick = rmq_pkg::PICK_Y;
    end
    if (c3 > big) begin
      big  = c3;
      pick = rmq_pkg::PICK_Z;
    end
    b1  = (BW+1)'(big) + ((BW+1)'(1) << FRAC_BITS);
    inv = b1[BW] | (b1 == '0);
    case (pick)
      rmq_pkg::PICK_W: begin
        d[0] = DIFW'(m[5]) - DIFW'(m[7]);
        d[1] = DIFW'(m[6]) - DIFW'(m[2]);
        d[2] = DIFW'(m[1]) - DIFW'(m[3]);
      end
      rmq_pkg::PICK_X: begin
        d[0] = DIFW'(m[5]) - DIFW'(m[7]);
        d[1] = DIFW'(m[1]) + DIFW'(m[3]);
        d[2] = DIFW'(m[6]) + DIFW'(m[2]);
      end
      rmq_pkg::PICK_Y: begin
        d[0] = DIFW'(m[6]) - DIFW'(m[2]);
        d[1] = DIFW'(m[1]) + DIFW'(m[3]);
        d[2] = DIFW'(m[5]) + DIFW'(m[7]);
      end
      default: begin
        d[0] = DIFW'(m[1]) - DIFW'(m[3]);
        d[1] = DIFW'(m[6]) + DIFW'(m[2]);
        d[2] = DIFW'(m[5]) + DIFW'(m[7]);
      end
    endcase
    for (int k = 0; k < 3; k++) begin
      sgn[k] = d[k][DIFW-1];
      mag[k] = sgn[k] ? DIFW'(-d[k]) : DIFW'(d[k]);
    end
  end

  // Front stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid0_r <= 1'b0;
    end else if (en) begin
      valid0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad0_r  <= VW'(b1[BW-1:0]) << (FRAC_BITS - 2);
      side0_r <= {mag, sgn, pick, inv};
    end
  end

  // Square-root chain.
  logic [HW:0]           sv;
  logic [HW:0][VW-1:0]   srad;
  logic [HW:0][HW+1:0]   srem;
  logic [HW:0][HW-1:0]   sroot;
  logic [HW:0][SW1-1:0]  sside;

  assign sv[0]    = valid0_r;
  assign srad[0]  = rad0_r;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sside[0] = side0_r;

  for (genvar i = 0; i < HW; i++) begin : g_sqrt
    rmq_sqrt_cell #(.VW(VW), .HW(HW), .SW(SW1)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_in (sv[i]),
      .rad_in   (srad[i]),
      .rem_in   (srem[i]),
      .root_in  (sroot[i]),
      .side_in  (sside[i]),
      .valid_out(sv[i+1]),
      .rad_out  (srad[i+1]),
      .rem_out  (srem[i+1]),
      .root_out (sroot[i+1]),
      .side_out (sside[i+1])
    );
  end

  // Dividends and divisor from the root.
  logic [HW-1:0]        h;
  logic [2:0][DIFW-1:0] hmag;
  logic [5:0]           hflags;

  assign h                = sroot[HW];
  assign {hmag, hflags}   = sside[HW];

  logic [NUMW:0]                dv;
  logic [NUMW:0][DW-1:0]        dden;
  logic [NUMW:0][2:0][NUMW-1:0] dnq;
  logic [NUMW:0][2:0][DW-1:0]   drem;
  logic [NUMW:0][SW2-1:0]       dside;

  assign dv[0]   = sv[HW];
  assign dden[0] = {h, 2'b00};
  assign drem[0] = '0;
  assign dside[0] = {hflags, h};

  for (genvar k = 0; k < 3; k++) begin : g_num
    assign dnq[0][k] = (NUMW'(hmag[k]) << FRAC_BITS) + NUMW'({h, 1'b0});
  end

  // Division chain, one quotient bit per cell.
  for (genvar i = 0; i < NUMW; i++) begin : g_div
    rmq_div_cell #(.NUMW(NUMW), .DW(DW), .SW(SW2)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_in (dv[i]),
      .den_in   (dden[i]),
      .nq_in    (dnq[i]),
      .rem_in   (drem[i]),
      .side_in  (dside[i]),
      .valid_out(dv[i+1]),
      .den_out  (dden[i+1]),
      .nq_out   (dnq[i+1]),
      .rem_out  (drem[i+1]),
      .side_out (dside[i+1])
    );
  end

  // Saturate a magnitude with its sign to the component range.
  function automatic logic [MW-1:0] sat(input logic neg, input logic [NUMW-1:0] q);
    logic [MW-1:0] r;
    if (!neg) begin
      r = (q > NUMW'(32767)) ? rmq_pkg::SAT_MAX : MW'(q);
    end else begin
      r = (q > NUMW'(32768)) ? rmq_pkg::SAT_MIN : MW'(-q);
    end
    return r;
  endfunction

  logic [2:0]      fsgn;
  rmq_pkg::pick_t  fpick;
  logic            finv;
  logic [HW-1:0]   fh;
  logic [MW-1:0]   hq;
  logic [MW-1:0]   lq [3];
  logic [MW-1:0]   qw, qx, qy, qz;
  logic [63:0]     tdata_nxt;

  // Place the root at the picked component and the quotients around it.
  always_comb begin
    fsgn  = dside[NUMW][SW2-1 -: 3];
    fpick = rmq_pkg::pick_t'(dside[NUMW][HW+2 -: 2]);
    finv  = dside[NUMW][HW];
    fh    = dside[NUMW][HW-1:0];
    hq = sat(1'b0, NUMW'(fh));
    for (int k = 0; k < 3; k++) begin
      lq[k] = sat(fsgn[k], dnq[NUMW][k]);
    end
    case (fpick)
      rmq_pkg::PICK_W: begin
        qw = hq;    qx = lq[0]; qy = lq[1]; qz = lq[2];
      end
      rmq_pkg::PICK_X: begin
        qw = lq[0]; qx = hq;    qy = lq[1]; qz = lq[2];
      end
      rmq_pkg::PICK_Y: begin
        qw = lq[0]; qx = lq[1]; qy = hq;    qz = lq[2];
      end
      default: begin
        qw = lq[0]; qx = lq[1]; qy = lq[2]; qz = hq;
      end
    endcase
    tdata_nxt = finv ? 64'd0 : {qw, qz, qy, qx};
  end

  // Output register.
  logic        out_tvalid_r;
  logic [63:0] out_tdata_r;
  logic        out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= dv[NUMW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= tdata_nxt;
      out_tuser_r <= finv;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ----- sv/rmq_checker.sv -----
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_top_defines.svh"
// Port-level checks on the converter.
module rmq_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [63:0]  out_tdata,
  input logic         out_tuser
);

  // A stalled result holds its flag and data.
  `RMQ_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  // An invalid matrix gives an all-zero quaternion.
  `RMQ_ASSERT(a_inv_zero, out_tvalid && out_tuser |-> out_tdata == 64'd0, "invalid result not zero")
  // Input is taken whenever no result is waiting.
  `RMQ_ASSERT(a_ready, !out_tvalid |-> in_tready, "input blocked with empty output")
  // Nothing leaves right after reset.
  `RMQ_ASSERT_ALWAYS(a_reset, !rst_n |=> !out_tvalid, "result after reset")

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

// ----- bench/rmq_checker.sv -----
`timescale 1ns / 1ps
// Watch both channels, compute the expected quaternion per accepted matrix
// and compare it with each accepted result in order.
module rmq_scoreboard #(
  parameter int FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [143:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata,
  input  logic         out_tuser,
  output int           fail_count,
  output int           pending,
  output int           n_matrices,
  output int           n_invalid,
  output int           n_saturated
);

  typedef struct packed {
    logic                          invalid;
    logic signed [rmq_pkg::MW-1:0] qw;
    logic signed [rmq_pkg::MW-1:0] qz;
    logic signed [rmq_pkg::MW-1:0] qy;
    logic signed [rmq_pkg::MW-1:0] qx;
  } quat_t;

  quat_t quat_fifo[$];

  // Round down square root of a non-negative value.
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // d * 2^FRAC_BITS / (4h), nearest with ties away from zero.
  function automatic longint pair_scale(longint d, longint unsigned h);
    longint unsigned mag;
    longint unsigned den;
    longint unsigned q;
    mag = (d < 0) ? longint'(-d) : d;
    den = h * 4;
    q = ((mag << FRAC_BITS) + den / 2) / den;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [rmq_pkg::MW-1:0] clamp16(longint v, ref bit hit);
    if (v > 32767) begin
      hit = 1;
      return rmq_pkg::SAT_MAX;
    end
    if (v < -32768) begin
      hit = 1;
      return rmq_pkg::SAT_MIN;
    end
    return v[rmq_pkg::MW-1:0];
  endfunction

  function automatic quat_t matrix_to_quat(logic [143:0] mat, ref bit hit);
    longint m[9];
    longint cand[4];
    longint big;
    longint c[4];
    longint unsigned h;
    rmq_pkg::pick_t pick;
    quat_t q;
    for (int i = 0; i < 9; i++) m[i] = longint'($signed(mat[16*i +: 16]));
    cand[0] = m[0] + m[4] + m[8];
    cand[1] = m[0] - m[4] - m[8];
    cand[2] = m[4] - m[0] - m[8];
    cand[3] = m[8] - m[0] - m[4];
    big = cand[0];
    pick = rmq_pkg::PICK_W;
    for (int i = 1; i < 4; i++) begin
      if (cand[i] > big) begin
        big = cand[i];
        pick = rmq_pkg::pick_t'(i);
      end
    end
    q = '0;
    big = big + (64'sd1 << FRAC_BITS);
    if (big <= 0) begin
      q.invalid = 1'b1;
      return q;
    end
    h = root_floor(longint'(big) << (FRAC_BITS - 2));
    case (pick)
      rmq_pkg::PICK_W: begin
        c[0] = h;
        c[1] = pair_scale(m[5] - m[7], h);
        c[2] = pair_scale(m[6] - m[2], h);
        c[3] = pair_scale(m[1] - m[3], h);
      end
      rmq_pkg::PICK_X: begin
        c[1] = h;
        c[0] = pair_scale(m[5] - m[7], h);
        c[2] = pair_scale(m[1] + m[3], h);
        c[3] = pair_scale(m[6] + m[2], h);
      end
      rmq_pkg::PICK_Y: begin
        c[2] = h;
        c[0] = pair_scale(m[6] - m[2], h);
        c[1] = pair_scale(m[1] + m[3], h);
        c[3] = pair_scale(m[5] + m[7], h);
      end
      default: begin
        c[3] = h;
        c[0] = pair_scale(m[1] - m[3], h);
        c[1] = pair_scale(m[6] + m[2], h);
        c[2] = pair_scale(m[5] + m[7], h);
      end
    endcase
    q.qx = clamp16(c[1], hit);
    q.qy = clamp16(c[2], hit);
    q.qz = clamp16(c[3], hit);
    q.qw = clamp16(c[0], hit);
    return q;
  endfunction

  // Predict on input transfers, compare on output transfers.
  always @(posedge clk) begin
    quat_t want;
    quat_t got;
    bit hit;
    if (!rst_n) begin
      fail_count <= 0;
      n_matrices <= 0;
      n_invalid <= 0;
      n_saturated <= 0;
      pending <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        hit = 0;
        want = matrix_to_quat(in_tdata, hit);
        quat_fifo.push_back(want);
        n_matrices <= n_matrices + 1;
        if (want.invalid) n_invalid <= n_invalid + 1;
        if (hit) n_saturated <= n_saturated + 1;
      end
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata};
        if (quat_fifo.size() == 0) begin
          $error("result transfer with no matrix outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = quat_fifo.pop_front();
          if (got != want) begin
            if (got.qx != want.qx)
              $error("quat_x: expected %0d, got %0d", want.qx, got.qx);
            if (got.qy != want.qy)
              $error("quat_y: expected %0d, got %0d", want.qy, got.qy);
            if (got.qz != want.qz)
              $error("quat_z: expected %0d, got %0d", want.qz, got.qz);
            if (got.qw != want.qw)
              $error("quat_w: expected %0d, got %0d", want.qw, got.qw);
            if (got.invalid != want.invalid)
              $error("invalid: expected %0d, got %0d", want.invalid, got.invalid);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= quat_fifo.size();
    end
  end
endmodule

// ----- bench/tb_rotation_matrix_to_quaternion_top.sv -----
`timescale 1ns / 1ps
module tb_rotation_matrix_to_quaternion_top;
  localparam int ONE = 1 << 14;
  localparam int RANDOM_MATRICES = 1230;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 120;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic         out_tuser;
  int           fail_count;
  int           pending;
  int           n_matrices;
  int           n_invalid;
  int           n_saturated;
  int           idle_cycles;
  logic [143:0] matrix_list[$];

  rotation_matrix_to_quaternion_top uut (.*);

  rmq_scoreboard chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .fail_count(fail_count), .pending(pending),
    .n_matrices(n_matrices), .n_invalid(n_invalid), .n_saturated(n_saturated)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Receiver stall pattern: random phases of free running, light stalls and heavy stalls.
  initial begin
    int mode;
    out_tready = 0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 200)) begin
        @(posedge clk);
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // End the run if nothing transfers for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic [143:0] pack9(int e[9]);
    logic [143:0] v;
    for (int i = 0; i < 9; i++) v[16*i +: 16] = 16'(e[i]);
    return v;
  endfunction

  // Axis rotation with cosine c and sine s about axis a.
  function automatic logic [143:0] axis_rot(int a, int c, int s);
    int e[9];
    for (int i = 0; i < 9; i++) e[i] = 0;
    e[4*a] = ONE;
    case (a)
      0: begin e[4] = c; e[5] = -s; e[7] = s; e[8] = c; end
      1: begin e[0] = c; e[2] = s; e[6] = -s; e[8] = c; end
      default: begin e[0] = c; e[1] = -s; e[3] = s; e[4] = c; end
    endcase
    return pack9(e);
  endfunction

  // Rotation-like matrix: a random axis rotation plus small noise.
  function automatic logic [143:0] near_rotation();
    int e[9];
    int a;
    int ang;
    real th;
    logic [143:0] v;
    a = $urandom_range(0, 2);
    ang = $urandom_range(0, 359);
    th = ang * 3.14159265358979 / 180.0;
    v = axis_rot(a, $rtoi($cos(th) * ONE), $rtoi($sin(th) * ONE));
    for (int i = 0; i < 9; i++) begin
      e[i] = $signed(v[16*i +: 16]) + $signed($urandom_range(0, 64)) - 32;
    end
    return pack9(e);
  endfunction

  function automatic logic [143:0] random_matrix();
    logic [143:0] v;
    int e[9];
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return near_rotation();
      6: begin
        for (int i = 0; i < 9; i++) e[i] = $urandom_range(0, 2 * ONE) - ONE;
        return pack9(e);
      end
      7: begin
        // Strongly negative diagonal drives the trace candidate low.
        for (int i = 0; i < 9; i++)
          e[i] = (i % 4 == 0) ? -int'($urandom_range(ONE, 32768)) : $urandom_range(0, 65535);
        return pack9(e);
      end
      default: begin
        for (int i = 0; i < 9; i++) v[16*i +: 16] = 16'($urandom_range(0, 65535));
        return v;
      end
    endcase
  endfunction

  initial begin
    int burst;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;

    // Directed: identity, each axis at 180 degrees, ties, extremes.
    matrix_list.push_back(pack9('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}));
    matrix_list.push_back(axis_rot(0, -ONE, 0));
    matrix_list.push_back(axis_rot(1, -ONE, 0));
    matrix_list.push_back(axis_rot(2, -ONE, 0));
    matrix_list.push_back(axis_rot(0, 11585, 11585));
    matrix_list.push_back(axis_rot(1, 11585, -11585));
    matrix_list.push_back(axis_rot(2, 0, ONE));
    matrix_list.push_back(pack9('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
    matrix_list.push_back(pack9('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}));
    matrix_list.push_back(pack9('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}));
    matrix_list.push_back(pack9('{32767, 32767, 32767, 32767, 32767, 32767,
                                  32767, 32767, 32767}));
    matrix_list.push_back(pack9('{-32768, -32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768, -32768}));
    matrix_list.push_back(pack9('{-32768, 32767, -32768, -32768, -32768,
                                  32767, 32767, -32768, -32768}));
    matrix_list.push_back(pack9('{32767, -32768, 32767, 32767, -32768,
                                  -32768, -32768, 32767, -32768}));
    matrix_list.push_back(pack9('{-ONE, 32767, 32767, -32768, -ONE, 32767,
                                  -32768, -32768, -ONE + 1}));
    matrix_list.push_back(pack9('{0, 0, 0, 0, 0, 0, 0, 0, -ONE}));
    matrix_list.push_back(pack9('{0, 0, 0, 0, 0, 0, 0, 0, -ONE - 1}));
    matrix_list.push_back(pack9('{5, 1, 2, 3, 5, 4, 6, 7, 5}));
    matrix_list.push_back(pack9('{100, 0, 0, 0, 100, 0, 0, 0, -100}));
    for (int i = 0; i < RANDOM_MATRICES; i++) matrix_list.push_back(random_matrix());

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Send in bursts with random gaps.
    while (matrix_list.size() != 0) begin
      burst = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
      while (burst > 0 && matrix_list.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= matrix_list.pop_front();
        @(posedge clk);
        while (!in_tready) @(posedge clk);
        burst--;
      end
      if (matrix_list.size() != 0 && $urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d matrices: %0d with no valid root, %0d with clamped parts.",
             n_matrices, n_invalid, n_saturated);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ----- rotation_matrix_to_quaternion_top.f -----
+incdir+sv
sv/rmq_pkg.sv
sv/rmq_sqrt_cell.sv
sv/rmq_div_cell.sv
sv/rotation_matrix_to_quaternion_top.sv
sv/rmq_checker.sv
bench/rmq_checker.sv
bench/tb_rotation_matrix_to_quaternion_top.sv
